/* design/spo_pkg.sv */
// ----------------------------------------------------------------------------
// spo_pkg: shared types and constants of the spiral order matrix reader
// Matrix geometry, field widths, codes and the walker control structs.
// ----------------------------------------------------------------------------
package spo_pkg;

  // matrix geometry
  localparam int MAX_DIM     = 16;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = 2 * IDX_W;

  // field widths
  localparam int DATA_W  = 32;
  localparam int DIM_W   = 5;
  localparam int BND_W   = 6;
  localparam int OUT_W   = 40;
  localparam int CFG_I_W = 2;
  localparam int LIN_W   = 2 * DIM_W;

  // input item kinds (tuser)
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_I_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_I_W-1:0] REG_NUM_COLS = 2'd1;

  typedef logic signed [BND_W-1:0] bnd_t;
  typedef logic [DIM_W-1:0]        dim_t;
  typedef logic [LIN_W-1:0]        lin_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // walker control from the top level
  typedef struct packed {
    logic restart;
    logic step;
  } walk_ctrl_t;

  // walker position and status
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             fin;
    logic             last;
  } walk_pos_t;

  // clamp a dimension register into 1..MAX_DIM
  function automatic dim_t eff_dim(input dim_t v);
    dim_t res;
    res = v;
    if (v == '0) begin
      res = dim_t'(1);
    end else if (v > dim_t'(MAX_DIM)) begin
      res = dim_t'(MAX_DIM);
    end
    return res;
  endfunction

endpackage

/* design/spo_walk.sv */
// ----------------------------------------------------------------------------
// spo_walk: spiral walker
// Keeps the four bounds, the current position and the direction, and steps
// one element clockwise per read word.
// ----------------------------------------------------------------------------
module spo_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  spo_pkg::walk_ctrl_t ctrl,
  input  spo_pkg::dim_t      rows,
  input  spo_pkg::dim_t      cols,
  output spo_pkg::walk_pos_t pos
);
  import spo_pkg::*;

  bnd_t left_r, right_r, top_r, bottom_r, row_r, col_r;
  bnd_t left_nxt, right_nxt, top_nxt, bottom_nxt, row_nxt, col_nxt;
  dir_t dir_r, dir_nxt;
  logic fin_r, fin_nxt;

  // one spiral step
  always_comb begin
    left_nxt   = left_r;
    right_nxt  = right_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    dir_nxt    = dir_r;
    case (dir_r)
      DIR_RIGHT: begin
        if (col_r < right_r) begin
          col_nxt = col_r + bnd_t'(1);
        end else begin
          dir_nxt = DIR_DOWN;
          top_nxt = top_r + bnd_t'(1);
          row_nxt = top_r + bnd_t'(1);
        end
      end
      DIR_DOWN: begin
        if (row_r < bottom_r) begin
          row_nxt = row_r + bnd_t'(1);
        end else begin
          dir_nxt   = DIR_LEFT;
          right_nxt = right_r - bnd_t'(1);
          col_nxt   = right_r - bnd_t'(1);
        end
      end
      DIR_LEFT: begin
        if (col_r > left_r) begin
          col_nxt = col_r - bnd_t'(1);
        end else begin
          dir_nxt    = DIR_UP;
          bottom_nxt = bottom_r - bnd_t'(1);
          row_nxt    = bottom_r - bnd_t'(1);
        end
      end
      default: begin
        if (row_r > top_r) begin
          row_nxt = row_r - bnd_t'(1);
        end else begin
          dir_nxt  = DIR_RIGHT;
          left_nxt = left_r + bnd_t'(1);
          col_nxt  = left_r + bnd_t'(1);
        end
      end
    endcase
    fin_nxt = !((left_nxt <= right_nxt) && (top_nxt <= bottom_nxt));
  end

  // walker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      right_r  <= '0;
      top_r    <= '0;
      bottom_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      dir_r    <= DIR_RIGHT;
      fin_r    <= 1'b0;
    end else if (ctrl.restart) begin
      left_r   <= '0;
      right_r  <= bnd_t'({1'b0, cols}) - bnd_t'(1);
      top_r    <= '0;
      bottom_r <= bnd_t'({1'b0, rows}) - bnd_t'(1);
      row_r    <= '0;
      col_r    <= '0;
      dir_r    <= DIR_RIGHT;
      fin_r    <= 1'b0;
    end else if (ctrl.step) begin
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      dir_r    <= dir_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign pos.row  = row_r[IDX_W-1:0];
  assign pos.col  = col_r[IDX_W-1:0];
  assign pos.fin  = fin_r;
  assign pos.last = fin_nxt;

endmodule

/* design/spiral_order_matrix_reader.sv */
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader: matrix store read back in clockwise spiral order
// Input words with tuser=0 fill the matrix row-major, tuser=1 words fetch the
// next spiral element.
//
// Channels: in_* carries one word per item, tuser selects write or read and
// tdata holds the element for a write. out_* returns one word per read:
// element, row and column in tdata, tlast on the final spiral element, tuser
// set once the spiral has run out (then all other fields are zero). cfg_*
// writes num_rows (index 0) or num_cols (index 1); each write rewinds the
// write position and restarts the spiral. Writes produce no output word.
// Path: a read word passes the store read stage, loaded at its accepting edge,
// and then the output register before it is offered on out_*.
// Throughput: one item per cycle while out_* is not stalled, set by the single read
// and write port of the element store and the one-step spiral walker.
// Reset: dimensions return to 1x1, write position and spiral restart; the
// element store is not cleared and needs no clearing pass.
// Stall: a stalled output word holds, one more read waits in the store read
// stage, and the input stalls after that.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [spo_pkg::DATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic                         in_tuser,   // [0] kind
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [spo_pkg::OUT_W-1:0]    out_tdata,  // [31:0] data, [35:32] row_index,
                                                   // [39:36] col_index
  output logic                         out_tlast,  // last
  output logic                         out_tuser,  // [0] exhausted
  // configuration write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spo_pkg::CFG_I_W-1:0]  cfg_index,
  input  logic [spo_pkg::DIM_W-1:0]    cfg_data
);
  import spo_pkg::*;

  logic [DATA_W-1:0] store [STORE_DEPTH];

  dim_t rows_r, cols_r, rows_nxt, cols_nxt;
  logic [ADDR_W-1:0] wr_pos_r, wr_pos_nxt;
  lin_t size_w;
  lin_t rd_lin;

  logic in_acc, wr_acc, rd_acc, cfg_acc, cfg_hit;
  logic s1_valid_r, s1_valid_nxt, s1_move;
  logic s1_exh_r, s1_last_r;
  logic [IDX_W-1:0] s1_row_r, s1_col_r;
  logic [DATA_W-1:0] rd_data_r;
  logic out_valid_nxt;

  walk_ctrl_t walk_ctrl;
  walk_pos_t  walk_pos;

  // handshakes
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS);
  assign s1_move   = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_acc    = in_acc && (in_tuser == KIND_WRITE);
  assign rd_acc    = in_acc && (in_tuser == KIND_READ);

  // dimension registers
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_acc && cfg_index == REG_NUM_ROWS) begin
      rows_nxt = eff_dim(cfg_data);
    end
    if (cfg_acc && cfg_index == REG_NUM_COLS) begin
      cols_nxt = eff_dim(cfg_data);
    end
  end

  // matrix size in elements
  assign size_w = lin_t'(rows_r) * lin_t'(cols_r);

  // row-major linear write position, wraps at the matrix size
  always_comb begin
    wr_pos_nxt = wr_pos_r;
    if (cfg_hit) begin
      wr_pos_nxt = '0;
    end else if (wr_acc) begin
      if (lin_t'(wr_pos_r) + lin_t'(1) == size_w) begin
        wr_pos_nxt = '0;
      end else begin
        wr_pos_nxt = wr_pos_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= dim_t'(1);
      cols_r   <= dim_t'(1);
      wr_pos_r <= '0;
    end else begin
      rows_r   <= rows_nxt;
      cols_r   <= cols_nxt;
      wr_pos_r <= wr_pos_nxt;
    end
  end

  // spiral walker
  assign walk_ctrl.restart = cfg_hit || wr_acc;
  assign walk_ctrl.step    = rd_acc && !walk_pos.fin;

  spo_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (walk_ctrl),
    .rows  (rows_nxt),
    .cols  (cols_nxt),
    .pos   (walk_pos)
  );

  // row-major linear read address of the spiral position
  assign rd_lin = lin_t'(walk_pos.row) * lin_t'(cols_r) + lin_t'(walk_pos.col);

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_acc) begin
      store[wr_pos_r] <= in_tdata;
    end
    if (rd_acc) begin
      rd_data_r <= store[rd_lin[ADDR_W-1:0]];
    end
  end

  // read stage alongside the store read
  assign s1_valid_nxt = rd_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      s1_exh_r  <= walk_pos.fin;
      s1_last_r <= walk_pos.last && !walk_pos.fin;
      s1_row_r  <= walk_pos.fin ? '0 : walk_pos.row;
      s1_col_r  <= walk_pos.fin ? '0 : walk_pos.col;
    end
  end

  // output register
  assign out_valid_nxt = s1_move ? 1'b1 : (out_tready ? 1'b0 : out_tvalid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else begin
      out_tvalid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_tdata <= {s1_col_r, s1_row_r, (s1_exh_r ? {DATA_W{1'b0}} : rd_data_r)};
      out_tlast <= s1_last_r;
      out_tuser <= s1_exh_r;
    end
  end

endmodule

/* design/spo_checker.sv */
// ----------------------------------------------------------------------------
// spo_checker: port-level checks of the spiral order matrix reader
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module spo_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [spo_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tlast,
  input logic                      out_tuser
);
  import spo_pkg::*;

  // an exhausted word carries no element and is never the last one
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0 && !out_tlast)
    else $error("exhausted word with nonzero payload");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output word changed");

  // reset empties the result channel
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind spiral_order_matrix_reader spo_checker u_spo_checker (.*);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the spiral order matrix reader
// Fills the matrix row-major and reads it back in clockwise spiral order under
// a range of dimension settings. A scoreboard class tracks the spiral walk and
// predicts every output word; the input and output sides stall at random, and
// one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spo_pkg::*;

  localparam int ITEMS       = 1950;
  localparam int LIMIT       = 400000;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_TAIL  = 250;

  // index that decodes to no register
  localparam logic [CFG_I_W-1:0] REG_SPARE = 2'd3;

  // one output word as predicted
  typedef struct {
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
    logic              exhausted;
  } spiral_word_t;

  // spiral walk tracker and output word check
  class spiral_checker;
    logic [DATA_W-1:0] elems [STORE_DEPTH];
    bit                written [STORE_DEPTH];
    dim_t              rows_reg;
    dim_t              cols_reg;
    int                wr_pos;
    bnd_t              left_b;
    bnd_t              right_b;
    bnd_t              top_b;
    bnd_t              bottom_b;
    bnd_t              cur_r;
    bnd_t              cur_c;
    dir_t              heading;
    bit                done;
    spiral_word_t      words_due[$];
    int                errors;

    function new();
      rows_reg = dim_t'(1);
      cols_reg = dim_t'(1);
      wr_pos   = 0;
      errors   = 0;
      rewind();
    endfunction

    function int clamp_dim(dim_t v);
      if (v == '0) return 1;
      if (v > dim_t'(MAX_DIM)) return MAX_DIM;
      return int'(v);
    endfunction

    function int matrix_size();
      return clamp_dim(rows_reg) * clamp_dim(cols_reg);
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    // back to the top-left corner, full bounds
    function void rewind();
      left_b   = '0;
      right_b  = bnd_t'(clamp_dim(cols_reg) - 1);
      top_b    = '0;
      bottom_b = bnd_t'(clamp_dim(rows_reg) - 1);
      cur_r    = '0;
      cur_c    = '0;
      heading  = DIR_RIGHT;
      done     = 1'b0;
    endfunction

    // one step along the spiral, shrinking a bound at each turn
    function void step_walk();
      case (heading)
        DIR_RIGHT: begin
          if (cur_c < right_b) cur_c++;
          else begin
            heading = DIR_DOWN;
            top_b++;
            cur_r = top_b;
          end
        end
        DIR_DOWN: begin
          if (cur_r < bottom_b) cur_r++;
          else begin
            heading = DIR_LEFT;
            right_b--;
            cur_c = right_b;
          end
        end
        DIR_LEFT: begin
          if (cur_c > left_b) cur_c--;
          else begin
            heading = DIR_UP;
            bottom_b--;
            cur_r = bottom_b;
          end
        end
        default: begin
          if (cur_r > top_b) cur_r--;
          else begin
            heading = DIR_RIGHT;
            left_b++;
            cur_c = left_b;
          end
        end
      endcase
      if (!(left_b <= right_b && top_b <= bottom_b)) done = 1'b1;
    endfunction

    function int cur_addr();
      return (int'(cur_r) * clamp_dim(cols_reg) + int'(cur_c)) % STORE_DEPTH;
    endfunction

    // a read here touches only entries that hold data
    function bit read_safe();
      return done || written[cur_addr()];
    endfunction

    function void note_config(logic [CFG_I_W-1:0] idx, dim_t val);
      if (idx == REG_NUM_ROWS) rows_reg = val;
      else if (idx == REG_NUM_COLS) cols_reg = val;
      else return;
      wr_pos = 0;
      rewind();
    endfunction

    function void note_input(logic kind, logic [DATA_W-1:0] value);
      spiral_word_t w;
      int           size;
      size = matrix_size();
      if (kind == KIND_WRITE) begin
        if (wr_pos >= size) wr_pos = 0;
        elems[wr_pos]   = value;
        written[wr_pos] = 1'b1;
        wr_pos++;
        if (wr_pos >= size) wr_pos = 0;
        rewind();
        return;
      end
      w = '{default: '0};
      if (done) begin
        w.exhausted = 1'b1;
      end else begin
        w.data = elems[cur_addr()];
        w.row  = cur_r[IDX_W-1:0];
        w.col  = cur_c[IDX_W-1:0];
        step_walk();
        w.last = done;
      end
      words_due = {words_due, w};
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] tdata, logic tlast, logic tuser);
      spiral_word_t w;
      if (words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, expected none, actual data %h last %b tuser %b",
                 $time, tdata, tlast, tuser);
        return;
      end
      w = words_due.pop_front();
      check_field("data", w.data, tdata[DATA_W-1:0]);
      check_field("row_index", DATA_W'(w.row), DATA_W'(tdata[DATA_W +: IDX_W]));
      check_field("col_index", DATA_W'(w.col), DATA_W'(tdata[DATA_W+IDX_W +: IDX_W]));
      check_field("last", DATA_W'(w.last), DATA_W'(tlast));
      check_field("exhausted", DATA_W'(w.exhausted), DATA_W'(tuser));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [DATA_W-1:0]  in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;
  logic               out_tlast;
  logic               out_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_I_W-1:0] cfg_index;
  logic [DIM_W-1:0]   cfg_data;

  bit            tx_idle;
  bit            rx_idle;
  bit            hold_req;
  int            items_sent;
  int            cycle_count;
  spiral_checker chk;

  spiral_order_matrix_reader uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // output word check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) chk.check_result(out_tdata, out_tlast, out_tuser);
  end

  // output side: random stall bursts and the long hold-off
  initial begin : receiver
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = 0;
      if (hold_req) begin
        hold_req   = 1'b0;
        out_tready = 1'b0;
        stall      = HOLD_CYCLES;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        stall      = $urandom_range(1, 12);
      end else begin
        out_tready = 1'b1;
      end
      if (stall > 1) repeat (stall - 1) @(negedge clk);
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [DATA_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly small sizes, now and then the clamped and full ones
  function automatic dim_t pick_dim();
    case ($urandom_range(0, 19))
      0:       return dim_t'(0);
      1:       return dim_t'($urandom_range(17, 31));
      2:       return dim_t'(MAX_DIM);
      default: return dim_t'($urandom_range(1, 6));
    endcase
  endfunction

  // offer one input word, return once it is taken
  task automatic push_word(input logic kind, input logic [DATA_W-1:0] value);
    int gap;
    gap = 0;
    if (tx_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chk.note_input(kind, value);
    items_sent++;
  endtask

  // read, or a write where the spiral would reach an empty entry
  task automatic push_read();
    if (chk.read_safe()) push_word(KIND_READ, $urandom);
    else push_word(KIND_WRITE, rand_elem());
  endtask

  task automatic write_reg(input logic [CFG_I_W-1:0] idx, input dim_t val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chk.note_config(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop offering and let every predicted word drain
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // new dimensions, then fills, reads, broken runs and noise
  task automatic run_phase(input dim_t rows_v, input dim_t cols_v);
    int size;
    int nseq;
    int pick;
    wait_idle();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_NUM_ROWS, rows_v);
      write_reg(REG_NUM_COLS, cols_v);
    end else begin
      write_reg(REG_NUM_COLS, cols_v);
      write_reg(REG_NUM_ROWS, rows_v);
    end
    size = chk.matrix_size();
    nseq = (size > 64) ? 1 : $urandom_range(2, 5);
    repeat (nseq) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        repeat (size) push_word(KIND_WRITE, rand_elem());
        // restart in the middle of a spiral
        if (pick == 7) begin
          repeat ($urandom_range(1, size)) push_read();
          push_word(KIND_WRITE, rand_elem());
        end
        repeat (size + $urandom_range(0, 2)) push_read();
      end else begin
        repeat ($urandom_range(4, 20)) begin
          if ($urandom_range(0, 1)) push_read();
          else push_word(KIND_WRITE, rand_elem());
        end
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_WRITE;
    cfg_valid  = 1'b0;
    cfg_index  = REG_NUM_ROWS;
    cfg_data   = '0;
    tx_idle    = 1'b0;
    rx_idle    = 1'b1;
    hold_req   = 1'b0;
    items_sent = 0;
    chk        = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // 1x1 after reset: single element, then read past the end
    push_word(KIND_WRITE, 32'h8000_0000);
    push_read();
    push_read();
    push_word(KIND_WRITE, 32'h7FFF_FFFF);
    push_read();

    // write to an unused index leaves the spiral ended
    wait_idle();
    write_reg(REG_SPARE, dim_t'(5));
    push_read();

    // 2x3 with value extremes, read under a long output hold-off
    wait_idle();
    write_reg(REG_NUM_ROWS, dim_t'(2));
    write_reg(REG_NUM_COLS, dim_t'(3));
    push_word(KIND_WRITE, 32'hFFFF_FFFF);
    push_word(KIND_WRITE, 32'h0000_0000);
    push_word(KIND_WRITE, 32'h0000_0001);
    push_word(KIND_WRITE, 32'h5555_5555);
    push_word(KIND_WRITE, 32'hAAAA_AAAA);
    push_word(KIND_WRITE, 32'h7FFF_FFFF);
    hold_req = 1'b1;
    repeat (7) push_read();
    // write past the size wraps to the first entry
    push_word(KIND_WRITE, 32'h8000_0000);
    repeat (2) push_read();

    // extreme sizes, including clamped register values
    tx_idle = 1'b1;
    run_phase(dim_t'(MAX_DIM), dim_t'(MAX_DIM));
    run_phase(dim_t'(1), dim_t'(MAX_DIM));
    run_phase(dim_t'(MAX_DIM), dim_t'(1));
    run_phase(dim_t'(0), dim_t'(31));
    run_phase(dim_t'(31), dim_t'(0));
    run_phase(dim_t'(1), dim_t'(1));

    // random phases, quiet at the end
    while (items_sent < ITEMS) begin
      if (items_sent < ITEMS - QUIET_TAIL) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end else begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      run_phase(pick_dim(), pick_dim());
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
